// File: rtl/urb_pkg.sv
// shared types, constants and the remainder step for the bounded random block
`default_nettype none

package urb_pkg;

  localparam int WORD_W = 32;
  localparam int BITS_PER_STAGE = 2;
  localparam int NUM_STAGES = WORD_W / BITS_PER_STAGE;

  typedef logic [WORD_W-1:0] word_t;

  // one slot of the divider pipeline, both remainder lanes side by side
  typedef struct packed {
    word_t divisor;
    word_t word;
    word_t thr_dvd;
    word_t thr_rem;
    word_t w_dvd;
    word_t w_rem;
    logic  low_bound;
  } div_pipe_t;

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic word_t rem_step(word_t rem, logic dvd_bit, word_t divisor);
    logic [WORD_W:0] trial;
    trial = {rem, dvd_bit};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
    return trial[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/urb_channels.sv
// valid/ready channel interfaces for requests and results
`default_nettype none

interface urb_in_if;
  logic         valid;
  logic         ready;
  logic [31:0]  bound;
  logic [31:0]  random_word;

  modport source (output valid, output bound, output random_word, input ready);
  modport sink (input valid, input bound, input random_word, output ready);
endinterface

interface urb_out_if;
  logic         valid;
  logic         ready;
  logic [31:0]  value;
  logic         accepted;

  modport source (output valid, output value, output accepted, input ready);
  modport sink (input valid, input value, input accepted, output ready);
endinterface

`default_nettype wire

// File: rtl/uniform_random_below_bound_top.sv
// top level of the bounded uniform random block (rejection sampling)
//
// in_ch carries one word per request: an exclusive bound and a 32-bit random
// word from an outside generator. out_ch returns one word per request, in
// order: value = random_word mod bound and accepted = 1, or value = 0 and
// accepted = 0 when the word lies below 2^32 mod bound (the source then sends
// the same bound again with a fresh word). bounds of zero or one give 0,
// accepted.
// the pipeline has one entry stage, 16 divider stages that each resolve 2
// quotient bits of both remainders (threshold and word) in parallel, and one
// compare/output stage.
// throughput is one word per cycle while out_ch.ready stays high; the restoring
// steps per stage set the clock path.
// every stage holds a valid bit and takes a new word when it is empty or its
// successor moves, so bubbles close up and a stalled receiver backs the
// pipeline up without loss; in_ch.ready drops only once all stages are full.
// synchronous reset empties the pipeline; there is no other state.
`default_nettype none

module uniform_random_below_bound_top (
  input  logic      clk,
  input  logic      rst,
  urb_in_if.sink    in_ch,
  urb_out_if.source out_ch
);
  import urb_pkg::*;

  // pipeline slots: index 0 after the entry stage, NUM_STAGES after the divider
  logic      stg_valid [NUM_STAGES+1];
  logic      stg_ready [NUM_STAGES+1];
  div_pipe_t stg_data  [NUM_STAGES+1];

  // entry: negated bound as threshold dividend, small-bound flag
  urb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_ch.valid),
    .up_ready    (in_ch.ready),
    .bound       (in_ch.bound),
    .random_word (in_ch.random_word),
    .dn_valid    (stg_valid[0]),
    .dn_ready    (stg_ready[0]),
    .dn_data     (stg_data[0])
  );

  // divider chain, two remainder lanes sharing the divisor
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
    urb_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  // accept/reject decision and output register
  urb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[NUM_STAGES]),
    .up_ready (stg_ready[NUM_STAGES]),
    .up_data  (stg_data[NUM_STAGES]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .value    (out_ch.value),
    .accepted (out_ch.accepted)
  );

`ifndef SYNTHESIS
  // finished remainders must lie below a real divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    stg_valid[NUM_STAGES] && (stg_data[NUM_STAGES].divisor[WORD_W-1:1] != '0)
      |-> (stg_data[NUM_STAGES].w_rem < stg_data[NUM_STAGES].divisor) &&
          (stg_data[NUM_STAGES].thr_rem < stg_data[NUM_STAGES].divisor))
    else $error("remainder not below divisor");

  // a rejected result carries a zero value
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.accepted |-> (out_ch.value == '0))
    else $error("rejected result with nonzero value");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_ch.valid && !stg_valid[0])
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// File: rtl/urb_front.sv
// entry stage: forms both dividends and flags bounds below two
`default_nettype none

module urb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  urb_pkg::word_t    bound,
  input  urb_pkg::word_t    random_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output urb_pkg::div_pipe_t dn_data
);
  import urb_pkg::*;

  div_pipe_t data_next;

  always_comb begin
    data_next.divisor   = bound;
    data_next.word      = random_word;
    // 2^32 mod b equals (2^32 - b) mod b, which fits the word
    data_next.thr_dvd   = word_t'(0) - bound;
    data_next.thr_rem   = '0;
    data_next.w_dvd     = random_word;
    data_next.w_rem     = '0;
    data_next.low_bound = (bound[WORD_W-1:1] == '0);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/urb_div_stage.sv
// one divider stage: BITS_PER_STAGE restoring steps on both remainder lanes
`default_nettype none

module urb_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  urb_pkg::div_pipe_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output urb_pkg::div_pipe_t dn_data
);
  import urb_pkg::*;

  div_pipe_t data_next;

  always_comb begin
    data_next = up_data;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      data_next.thr_rem = rem_step(data_next.thr_rem, data_next.thr_dvd[WORD_W-1],
                                   data_next.divisor);
      data_next.thr_dvd = data_next.thr_dvd << 1;
      data_next.w_rem   = rem_step(data_next.w_rem, data_next.w_dvd[WORD_W-1],
                                   data_next.divisor);
      data_next.w_dvd   = data_next.w_dvd << 1;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/urb_back.sv
// exit stage: threshold compare and registered result word
`default_nettype none

module urb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  urb_pkg::div_pipe_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output urb_pkg::word_t     value,
  output logic               accepted
);
  import urb_pkg::*;

  logic  above;
  logic  accepted_next;
  word_t value_next;

  always_comb begin
    above         = (up_data.word >= up_data.thr_rem);
    accepted_next = up_data.low_bound || above;
    value_next    = (!up_data.low_bound && above) ? up_data.w_rem : '0;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      value    <= value_next;
      accepted <= accepted_next;
    end
  end

endmodule

`default_nettype wire
